// ----- sv/slr_pkg.sv -----
// package for the scaling list reconstruction block
// holds phase and controller state codes, command/status structs and default tables
// no dependencies
package slr_pkg;

  localparam logic [7:0] COEF_START = 8'd8;
  localparam logic [7:0] DC_DEFAULT = 8'd16;
  localparam logic [7:0] FLAT_COEF  = 8'd16;

  // which syntax element is expected next
  typedef enum logic [1:0] {
    PH_FLAG  = 2'd0,
    PH_DELTA = 2'd1,
    PH_DC    = 2'd2,
    PH_COEF  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE    = 2'd0,
    ST_EVAL    = 2'd1,
    ST_CP_RD   = 2'd2,
    ST_CP_EMIT = 2'd3
  } ctl_state_e;

  typedef struct packed {
    logic accept;
    logic single;
    logic copy_init;
    logic copy_read;
    logic copy_emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic copy_go;
    logic copy_last;
    logic out_free;
  } dp_status_t;

  localparam logic [7:0] DFLT_INTRA [64] = '{
    8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16,
    8'd16, 8'd16, 8'd17, 8'd16, 8'd17, 8'd16, 8'd17, 8'd18,
    8'd17, 8'd18, 8'd18, 8'd17, 8'd18, 8'd21, 8'd19, 8'd20,
    8'd21, 8'd20, 8'd19, 8'd21, 8'd24, 8'd22, 8'd22, 8'd24,
    8'd24, 8'd22, 8'd22, 8'd24, 8'd25, 8'd25, 8'd27, 8'd30,
    8'd27, 8'd25, 8'd25, 8'd29, 8'd31, 8'd35, 8'd35, 8'd31,
    8'd29, 8'd36, 8'd41, 8'd44, 8'd41, 8'd36, 8'd47, 8'd54,
    8'd54, 8'd47, 8'd65, 8'd70, 8'd65, 8'd88, 8'd88, 8'd115
  };

  localparam logic [7:0] DFLT_INTER [64] = '{
    8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16, 8'd16,
    8'd16, 8'd16, 8'd17, 8'd17, 8'd17, 8'd17, 8'd17, 8'd18,
    8'd18, 8'd18, 8'd18, 8'd18, 8'd18, 8'd20, 8'd20, 8'd20,
    8'd20, 8'd20, 8'd20, 8'd20, 8'd24, 8'd24, 8'd24, 8'd24,
    8'd24, 8'd24, 8'd24, 8'd24, 8'd25, 8'd25, 8'd25, 8'd25,
    8'd25, 8'd25, 8'd25, 8'd28, 8'd28, 8'd28, 8'd28, 8'd28,
    8'd28, 8'd33, 8'd33, 8'd33, 8'd33, 8'd33, 8'd41, 8'd41,
    8'd41, 8'd41, 8'd54, 8'd54, 8'd54, 8'd71, 8'd71, 8'd91
  };

endpackage

// ----- sv/slr_ram.sv -----
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module slr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/slr_ctrl.sv -----
// controller state machine for the scaling list reconstruction block
// depends on slr_pkg
module slr_ctrl import slr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  dp_status_t status_i,
  output ctl_cmd_t   cmd_o
);

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (status_i.copy_go) state_d = ST_CP_RD;
        else if (status_i.out_free) state_d = ST_IDLE;
      end
      ST_CP_RD: begin
        state_d = ST_CP_EMIT;
      end
      ST_CP_EMIT: begin
        if (status_i.out_free) state_d = status_i.copy_last ? ST_IDLE : ST_CP_RD;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i;
      end
      ST_EVAL: begin
        cmd_o.copy_init = status_i.copy_go;
        cmd_o.single    = !status_i.copy_go && status_i.out_free;
      end
      ST_CP_RD: begin
        cmd_o.copy_read = 1'b1;
      end
      ST_CP_EMIT: begin
        cmd_o.copy_emit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

// ----- sv/slr_dp.sv -----
// datapath: position counters, dpcm reconstruction, dc store, coefficient ram, output register
// depends on slr_pkg and slr_ram
module slr_dp import slr_pkg::*; #(
  parameter int LIST_LENGTH  = 64,
  parameter int MATRIX_COUNT = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctl_cmd_t    cmd_i,
  output dp_status_t  status_o,
  input  logic [8:0]  symbol_value_i,
  input  logic        restart_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output logic [7:0]  coef_value_o,
  output logic [5:0]  coef_index_o,
  output logic [1:0]  size_class_o,
  output logic [2:0]  matrix_number_o,
  output logic        coef_present_o,
  output logic [7:0]  dc_value_o,
  output logic        dc_present_o,
  output logic        run_last_o,
  output logic        set_done_o,
  output logic        error_o
);

  localparam int IW    = $clog2(LIST_LENGTH);
  localparam int DEPTH = 4 * MATRIX_COUNT * LIST_LENGTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int DCN   = 2 * MATRIX_COUNT;
  localparam int DW    = $clog2(DCN);

  typedef struct packed {
    logic [7:0] coef_value;
    logic [5:0] coef_index;
    logic [1:0] size_class;
    logic [2:0] matrix_number;
    logic       coef_present;
    logic [7:0] dc_value;
    logic       dc_present;
    logic       run_last;
    logic       set_done;
    logic       error;
  } res_t;

  logic [1:0]    size_q, size_d;
  logic [2:0]    matrix_q, matrix_d;
  logic [IW-1:0] pos_q, pos_d;
  phase_e        phase_q, phase_d;
  logic [7:0]    running_q, running_d;
  logic [IW-1:0] elem_q, elem_d;
  logic [2:0]    ref_q, ref_d;
  logic          dflt_q, dflt_d;
  logic [8:0]    sym_q;
  logic          out_valid_q;
  res_t          res_q, res;

  logic          load_out, adv, matrix_last;
  logic [IW-1:0] cnt_m1, widx;
  logic          flag0, flag1, delta_ok, dc_ok, coef_ok;
  logic [7:0]    nc, dcv, dflt_coef, copy_coef, copy_dc;
  logic [2:0]    ref_c;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic          dc_we, dc_re;
  logic [DW-1:0] dc_waddr, dc_raddr, dc_base;
  logic [7:0]    dc_wdata, dc_rdata;

  // last position of a list in the current size class (list length minus one)
  assign cnt_m1 = (size_q == 2'd0) ? IW'(15) : IW'(LIST_LENGTH - 1);
  assign matrix_last = (size_q == 2'd3) ? (matrix_q == 3'd1)
                                        : (matrix_q == 3'(MATRIX_COUNT - 1));

  assign flag0    = (sym_q == 9'd0);
  assign flag1    = (sym_q == 9'd1);
  assign delta_ok = !sym_q[8] && (sym_q[7:0] <= {5'd0, matrix_q});
  assign dc_ok    = ($signed(sym_q) >= -9'sd7) && ($signed(sym_q) <= 9'sd247);
  assign dcv      = sym_q[7:0] + COEF_START;
  assign nc       = running_q + sym_q[7:0];
  assign coef_ok  = (sym_q[8] == sym_q[7]) && (nc != 8'd0);
  assign ref_c    = matrix_q - sym_q[2:0];

  // default table pick: flat for 4x4, intra for the first half of the matrices
  always_comb begin
    if (size_q == 2'd0) begin
      dflt_coef = FLAT_COEF;
    end else if ((size_q == 2'd3) ? (matrix_q == 3'd0)
                                  : (matrix_q < 3'(MATRIX_COUNT / 2))) begin
      dflt_coef = DFLT_INTRA[6'(elem_q)];
    end else begin
      dflt_coef = DFLT_INTER[6'(elem_q)];
    end
  end
  assign copy_coef = dflt_q ? dflt_coef : ram_rdata;
  // dc of the reference list, read once when the copy starts
  assign copy_dc   = dflt_q ? DC_DEFAULT : dc_rdata;

  assign dc_base  = size_q[0] ? DW'(MATRIX_COUNT) : '0;
  assign dc_waddr = dc_base + DW'(matrix_q);
  assign dc_raddr = dc_base + DW'(ref_c);
  assign dc_re    = cmd_i.copy_init;

  assign widx      = cmd_i.copy_emit ? elem_q : pos_q;
  assign ram_waddr = (AW'(size_q) * AW'(MATRIX_COUNT) + AW'(matrix_q)) * AW'(LIST_LENGTH)
                     + AW'(widx);
  assign ram_raddr = (AW'(size_q) * AW'(MATRIX_COUNT) + AW'(ref_q)) * AW'(LIST_LENGTH)
                     + AW'(elem_q);

  always_comb begin
    size_d    = size_q;
    matrix_d  = matrix_q;
    pos_d     = pos_q;
    phase_d   = phase_q;
    running_d = running_q;
    elem_d    = elem_q;
    ref_d     = ref_q;
    dflt_d    = dflt_q;
    res       = '0;
    res.size_class    = size_q;
    res.matrix_number = matrix_q;
    load_out  = 1'b0;
    adv       = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = nc;
    dc_we     = 1'b0;
    dc_wdata  = dcv;

    if (cmd_i.accept && restart_i) begin
      size_d    = 2'd0;
      matrix_d  = 3'd0;
      pos_d     = '0;
      phase_d   = PH_FLAG;
      running_d = COEF_START;
    end

    if (cmd_i.single) begin
      load_out     = 1'b1;
      res.run_last = 1'b1;
      case (phase_q)
        PH_FLAG: begin
          if (flag0) begin
            phase_d = PH_DELTA;
          end else if (flag1) begin
            phase_d   = size_q[1] ? PH_DC : PH_COEF;
            pos_d     = '0;
            running_d = COEF_START;
          end else begin
            res.error = 1'b1;
          end
        end
        PH_DC: begin
          if (dc_ok) begin
            dc_we          = size_q[1];
            running_d      = dcv;
            pos_d          = '0;
            phase_d        = PH_COEF;
            res.dc_value   = dcv;
            res.dc_present = 1'b1;
          end else begin
            res.error = 1'b1;
          end
        end
        PH_COEF: begin
          if (coef_ok) begin
            ram_we           = 1'b1;
            running_d        = nc;
            res.coef_value   = nc;
            res.coef_index   = 6'(pos_q);
            res.coef_present = 1'b1;
            if (pos_q == cnt_m1) adv = 1'b1;
            else pos_d = pos_q + 1'b1;
          end else begin
            res.error = 1'b1;
          end
        end
        default: begin
          // matrix delta out of range
          res.error = 1'b1;
        end
      endcase
    end

    if (cmd_i.copy_init) begin
      elem_d = '0;
      ref_d  = ref_c;
      dflt_d = flag0;
    end

    if (cmd_i.copy_emit) begin
      load_out         = 1'b1;
      ram_we           = 1'b1;
      ram_wdata        = copy_coef;
      res.coef_value   = copy_coef;
      res.coef_index   = 6'(elem_q);
      res.coef_present = 1'b1;
      res.dc_present   = (elem_q == '0) && size_q[1];
      res.dc_value     = res.dc_present ? copy_dc : 8'd0;
      // the copied dc goes to the store with the first coefficient
      dc_we            = res.dc_present;
      dc_wdata         = copy_dc;
      res.run_last     = (elem_q == cnt_m1);
      if (elem_q == cnt_m1) adv = 1'b1;
      else elem_d = elem_q + 1'b1;
    end

    // move on to the next list
    if (adv) begin
      phase_d   = PH_FLAG;
      pos_d     = '0;
      running_d = COEF_START;
      if (matrix_last) begin
        matrix_d = 3'd0;
        if (size_q == 2'd3) begin
          size_d       = 2'd0;
          res.set_done = 1'b1;
        end else begin
          size_d = size_q + 2'd1;
        end
      end else begin
        matrix_d = matrix_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q      <= 2'd0;
      matrix_q    <= 3'd0;
      pos_q       <= '0;
      phase_q     <= PH_FLAG;
      running_q   <= COEF_START;
      elem_q      <= '0;
      ref_q       <= 3'd0;
      dflt_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      size_q    <= size_d;
      matrix_q  <= matrix_d;
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      running_q <= running_d;
      elem_q    <= elem_d;
      ref_q     <= ref_d;
      dflt_q    <= dflt_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) sym_q <= symbol_value_i;
    if (load_out) res_q <= res;
  end

  slr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.copy_read),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  slr_ram #(
    .WIDTH (8),
    .DEPTH (DCN)
  ) u_dc_ram (
    .clk_i   (clk_i),
    .we_i    (dc_we),
    .waddr_i (dc_waddr),
    .wdata_i (dc_wdata),
    .re_i    (dc_re),
    .raddr_i (dc_raddr),
    .rdata_o (dc_rdata)
  );

  assign status_o.copy_go   = (phase_q == PH_DELTA) && delta_ok;
  assign status_o.copy_last = (elem_q == cnt_m1);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign out_valid_o     = out_valid_q;
  assign coef_value_o    = res_q.coef_value;
  assign coef_index_o    = res_q.coef_index;
  assign size_class_o    = res_q.size_class;
  assign matrix_number_o = res_q.matrix_number;
  assign coef_present_o  = res_q.coef_present;
  assign dc_value_o      = res_q.dc_value;
  assign dc_present_o    = res_q.dc_present;
  assign run_last_o      = res_q.run_last;
  assign set_done_o      = res_q.set_done;
  assign error_o         = res_q.error;

endmodule

// ----- sv/scaling_list_reconstruct_top.sv -----
// top level of the scaling list reconstruction block
// depends on slr_pkg, slr_ctrl, slr_dp (which holds slr_ram)
//
// channel  direction  handshake                 word
// in       input      in_valid_i / in_stall_o   symbol_value_i, restart_i
// out      output     out_valid_o / out_stall_i coefficient, position, dc and flag fields
//
// a syntax word that yields one result goes through evaluation before the block is idle again;
// a predicted list of N coefficients (16 or LIST_LENGTH) runs a read/emit loop: each element
// is read on the coefficient ram read port and then loaded into the output register
// reset clears counters, phase and running coefficient; coefficient ram and dc store are not
// cleared and hold junk until written in the current walk
// out_stall_i only delays the next result; a new word is taken while a result still waits
module scaling_list_reconstruct_top import slr_pkg::*; #(
  parameter int LIST_LENGTH  = 64,
  parameter int MATRIX_COUNT = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input words
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [8:0] symbol_value_i,
  input  logic       restart_i,
  // result words
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] coef_value_o,
  output logic [5:0] coef_index_o,
  output logic [1:0] size_class_o,
  output logic [2:0] matrix_number_o,
  output logic       coef_present_o,
  output logic [7:0] dc_value_o,
  output logic       dc_present_o,
  output logic       run_last_o,
  output logic       set_done_o,
  output logic       error_o
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // sequencer: accept, evaluate, and read/emit loop for predicted lists
  slr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // counters, dpcm, stores and output register
  slr_dp #(
    .LIST_LENGTH  (LIST_LENGTH),
    .MATRIX_COUNT (MATRIX_COUNT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .symbol_value_i  (symbol_value_i),
    .restart_i       (restart_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .coef_value_o    (coef_value_o),
    .coef_index_o    (coef_index_o),
    .size_class_o    (size_class_o),
    .matrix_number_o (matrix_number_o),
    .coef_present_o  (coef_present_o),
    .dc_value_o      (dc_value_o),
    .dc_present_o    (dc_present_o),
    .run_last_o      (run_last_o),
    .set_done_o      (set_done_o),
    .error_o         (error_o)
  );

`ifndef SYNTHESIS
  // an accepted word keeps the block busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after an accept");

  // set completion only on the closing word of an item
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && set_done_o |-> run_last_o)
    else $error("set_done without run_last");

  // a dropped word gives a single result with no coefficient
  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> run_last_o && !coef_present_o && !dc_present_o)
    else $error("error result carries data");

  // dc only exists for 16x16 and 32x32 lists
  a_dc_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && dc_present_o |-> size_class_o[1])
    else $error("dc value on a small size class");
`endif

endmodule

// ----- tb/scaling_list_reconstruct_checker.sv -----
// checker for the scaling list reconstruction block: follows both channels, predicts
// every result word from the accepted syntax words and compares them field by field
// depends on slr_pkg for the phase codes, start values and default tables
`timescale 1ns / 100ps

module scaling_list_reconstruct_checker import slr_pkg::*; #(
  parameter int LIST_LENGTH  = 64,
  parameter int MATRIX_COUNT = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [8:0] symbol_value_i,
  input  logic       restart_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [7:0] coef_value_i,
  input  logic [5:0] coef_index_i,
  input  logic [1:0] size_class_i,
  input  logic [2:0] matrix_number_i,
  input  logic       coef_present_i,
  input  logic [7:0] dc_value_i,
  input  logic       dc_present_i,
  input  logic       run_last_i,
  input  logic       set_done_i,
  input  logic       error_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         words_checked_o,
  output int         sets_done_o
);

  typedef struct packed {
    logic [7:0] coef_value;
    logic [5:0] coef_index;
    logic [1:0] size_class;
    logic [2:0] matrix_number;
    logic       coef_present;
    logic [7:0] dc_value;
    logic       dc_present;
    logic       run_last;
    logic       set_done;
    logic       error;
  } result_t;

  localparam int STORE_DEPTH = 4 * MATRIX_COUNT * LIST_LENGTH;

  string field_name [10] = '{"coef_value", "coef_index", "size_class", "matrix_number",
                             "coef_present", "dc_value", "dc_present", "run_last",
                             "set_done", "error"};

  // own copy of the list stores and walk counters
  logic [7:0] coef_mem [STORE_DEPTH];
  logic [7:0] dc_mem [2 * MATRIX_COUNT];
  int         size_pos;
  int         mtx_pos;
  int         coef_pos;
  phase_e     phase;
  logic [7:0] running;

  result_t    due_q[$];
  result_t    got;
  result_t    want;
  int         fails;
  int         checked;
  int         sets;

  function automatic int lists_in(int sz);
    return (sz == 3) ? 2 : MATRIX_COUNT;
  endfunction

  function automatic int coefs_in(int sz);
    int n;
    n = 16 << (2 * sz);
    return (n < LIST_LENGTH) ? n : LIST_LENGTH;
  endfunction

  function automatic int slot(int sz, int mx, int i);
    return ((sz * MATRIX_COUNT + mx) * LIST_LENGTH + i) % STORE_DEPTH;
  endfunction

  function automatic logic [7:0] default_coef(int sz, int mx, int i);
    if (sz == 0) return FLAT_COEF;
    if (mx < lists_in(sz) / 2) return DFLT_INTRA[i % 64];
    return DFLT_INTER[i % 64];
  endfunction

  // step to the next list, returns 1 when the whole set wrapped
  function automatic logic next_list();
    logic done;
    done     = 1'b0;
    phase    = PH_FLAG;
    coef_pos = 0;
    running  = COEF_START;
    mtx_pos++;
    if (mtx_pos >= lists_in(size_pos)) begin
      mtx_pos = 0;
      if (size_pos == 3) begin
        size_pos = 0;
        done     = 1'b1;
      end else begin
        size_pos++;
      end
    end
    return done;
  endfunction

  task automatic predict_words(input logic [8:0] sym, input logic rs);
    int         v;
    int         sz;
    int         mx;
    int         cnt;
    int         refm;
    int         pos;
    logic [7:0] c;
    logic [7:0] nc;
    logic [7:0] dcv;
    logic       done;
    result_t    r;
    result_t    w;
    v = $signed(sym);
    if (rs) begin
      size_pos = 0;
      mtx_pos  = 0;
      coef_pos = 0;
      phase    = PH_FLAG;
      running  = COEF_START;
    end
    if (mtx_pos >= lists_in(size_pos)) mtx_pos = 0;
    sz   = size_pos;
    mx   = mtx_pos;
    cnt  = coefs_in(sz);
    done = 1'b0;
    r    = '0;
    r.size_class    = sz[1:0];
    r.matrix_number = mx[2:0];
    case (phase)
      PH_FLAG: begin
        if (v == 0) begin
          phase = PH_DELTA;
        end else if (v == 1) begin
          phase    = (sz >= 2) ? PH_DC : PH_COEF;
          coef_pos = 0;
          running  = COEF_START;
        end else begin
          r.error = 1'b1;
        end
        due_q.push_back(r);
      end
      PH_DELTA: begin
        if (v < 0 || v > mx) begin
          r.error = 1'b1;
          due_q.push_back(r);
        end else begin
          // copy of a reference list, delta 0 means the default table
          refm = mx - v;
          dcv  = '0;
          if (sz >= 2) begin
            dcv = (v == 0) ? DC_DEFAULT : dc_mem[(sz - 2) * MATRIX_COUNT + refm];
            dc_mem[(sz - 2) * MATRIX_COUNT + mx] = dcv;
          end
          for (int i = 0; i < cnt; i++) begin
            c = (v == 0) ? default_coef(sz, mx, i) : coef_mem[slot(sz, refm, i)];
            coef_mem[slot(sz, mx, i)] = c;
            w = r;
            w.coef_value   = c;
            w.coef_index   = i[5:0];
            w.coef_present = 1'b1;
            if (i == 0 && sz >= 2) begin
              w.dc_value   = dcv;
              w.dc_present = 1'b1;
            end
            due_q.push_back(w);
          end
          done = next_list();
        end
      end
      PH_DC: begin
        if (v < -7 || v > 247) begin
          r.error = 1'b1;
        end else begin
          dcv = 8'(v + 8);
          if (sz >= 2) dc_mem[(sz - 2) * MATRIX_COUNT + mx] = dcv;
          running      = dcv;
          coef_pos     = 0;
          phase        = PH_COEF;
          r.dc_value   = dcv;
          r.dc_present = 1'b1;
        end
        due_q.push_back(r);
      end
      default: begin
        nc = 8'(int'(running) + v);
        if (v < -128 || v > 127 || nc == 8'd0) begin
          r.error = 1'b1;
          due_q.push_back(r);
        end else begin
          pos     = coef_pos % cnt;
          running = nc;
          coef_mem[slot(sz, mx, pos)] = nc;
          r.coef_value   = nc;
          r.coef_index   = pos[5:0];
          r.coef_present = 1'b1;
          due_q.push_back(r);
          coef_pos = pos + 1;
          if (coef_pos >= cnt) done = next_list();
        end
      end
    endcase
    w = due_q.pop_back();
    w.run_last = 1'b1;
    w.set_done = done;
    due_q.push_back(w);
  endtask

  function automatic bit word_differs(result_t w_exp, result_t w_act);
    int e_f [10];
    int a_f [10];
    bit bad;
    e_f = '{w_exp.coef_value, w_exp.coef_index, w_exp.size_class, w_exp.matrix_number,
            w_exp.coef_present, w_exp.dc_value, w_exp.dc_present, w_exp.run_last,
            w_exp.set_done, w_exp.error};
    a_f = '{w_act.coef_value, w_act.coef_index, w_act.size_class, w_act.matrix_number,
            w_act.coef_present, w_act.dc_value, w_act.dc_present, w_act.run_last,
            w_act.set_done, w_act.error};
    bad = 1'b0;
    foreach (e_f[k]) begin
      if (e_f[k] != a_f[k]) begin
        $display("t=%0t %s expected %0d, got %0d", $time, field_name[k], e_f[k], a_f[k]);
        bad = 1'b1;
      end
    end
    return bad;
  endfunction

  // channel values are sampled as they stood before the edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_pos = 0;
      mtx_pos  = 0;
      coef_pos = 0;
      phase    = PH_FLAG;
      running  = COEF_START;
      due_q.delete();
      fails    = 0;
      checked  = 0;
      sets     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {coef_value_i, coef_index_i, size_class_i, matrix_number_i, coef_present_i,
               dc_value_i, dc_present_i, run_last_i, set_done_i, error_i};
        if (due_q.size() == 0) begin
          $display("t=%0t result word with nothing expected: value %0d index %0d error %0d",
                   $time, coef_value_i, coef_index_i, error_i);
          fails++;
        end else begin
          want = due_q.pop_front();
          if (word_differs(want, got)) fails++;
          if (want.set_done) sets++;
        end
        checked++;
      end
      if (in_valid_i && !in_stall_i) predict_words(symbol_value_i, restart_i);
    end
    fail_count_o    <= fails;
    pending_o       <= due_q.size();
    words_checked_o <= checked;
    sets_done_o     <= sets;
  end

endmodule

// ----- tb/scaling_list_reconstruct_top_tb.sv -----
// testbench top for the scaling list reconstruction block: drives syntax words and stalls,
// the checker beside the block predicts and compares, this module gives the verdict
// depends on slr_pkg, scaling_list_reconstruct_top and scaling_list_reconstruct_checker
`timescale 1ns / 100ps

module scaling_list_reconstruct_top_tb import slr_pkg::*; ();

  localparam int LIST_LEN  = 64;
  localparam int MTX_COUNT = 6;
  localparam int ITEMS     = 460;
  // no handshake on either side for this long means the block is stuck
  localparam int WATCHDOG  = 1000;
  // extra wait after the last expected result has come, so that stray words can show up
  localparam int DRAIN     = 150;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  logic [8:0] symbol    = '0;
  logic       restart   = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] coef_value;
  logic [5:0] coef_index;
  logic [1:0] size_class;
  logic [2:0] matrix_number;
  logic       coef_present;
  logic [7:0] dc_value;
  logic       dc_present;
  logic       run_last;
  logic       set_done;
  logic       error;

  int   fail_count;
  int   pending;
  int   words_checked;
  int   sets_done;

  // words sent so far; calm switches idling off on both sides for a stretch
  int   sent        = 0;
  logic calm        = 1'b0;
  int   idle_cycles = 0;

  always #1 clk = ~clk;

  scaling_list_reconstruct_top #(
    .LIST_LENGTH  (LIST_LEN),
    .MATRIX_COUNT (MTX_COUNT)
  ) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .symbol_value_i  (symbol),
    .restart_i       (restart),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .coef_value_o    (coef_value),
    .coef_index_o    (coef_index),
    .size_class_o    (size_class),
    .matrix_number_o (matrix_number),
    .coef_present_o  (coef_present),
    .dc_value_o      (dc_value),
    .dc_present_o    (dc_present),
    .run_last_o      (run_last),
    .set_done_o      (set_done),
    .error_o         (error)
  );

  scaling_list_reconstruct_checker #(
    .LIST_LENGTH  (LIST_LEN),
    .MATRIX_COUNT (MTX_COUNT)
  ) checker_inst (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .symbol_value_i  (symbol),
    .restart_i       (restart),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .coef_value_i    (coef_value),
    .coef_index_i    (coef_index),
    .size_class_i    (size_class),
    .matrix_number_i (matrix_number),
    .coef_present_i  (coef_present),
    .dc_value_i      (dc_value),
    .dc_present_i    (dc_present),
    .run_last_i      (run_last),
    .set_done_i      (set_done),
    .error_i         (error),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked),
    .sets_done_o     (sets_done)
  );

  // receiver stalls at random about a fifth of the time, never during the calm stretch
  always @(posedge clk) begin
    out_stall <= rst_n && !calm && ($urandom_range(0, 99) < 20);
  end

  // watchdog: counts cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("t=%0t watchdog: no word moved for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one syntax word, with random idle cycles ahead of it; returns at the accepting edge
  task automatic send_word(input int v, input logic rs);
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    symbol   <= v[8:0];
    restart  <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    calm = (sent >= 150 && sent < 260);
  endtask

  // coefficient delta that keeps the running coefficient nonzero, leaning on the extremes
  function automatic int pick_delta(int run);
    int d;
    do begin
      case ($urandom_range(0, 3))
        0:       d = 127;
        1:       d = -128;
        default: d = int'($urandom_range(0, 255)) - 128;
      endcase
    end while (((run + d) & 255) == 0);
    return d;
  endfunction

  // dc minus 8, legal range -7..247
  function automatic int pick_dc();
    case ($urandom_range(0, 3))
      0:       return -7;
      1:       return 247;
      default: return int'($urandom_range(0, 254)) - 7;
    endcase
  endfunction

  // a value the block must drop in the given phase
  function automatic int bad_value(phase_e ph, int mx, int run);
    int v;
    case (ph)
      PH_FLAG: begin
        do v = int'($urandom_range(0, 383)) - 128; while (v == 0 || v == 1);
      end
      PH_DELTA: begin
        v = $urandom_range(0, 1) ? -int'($urandom_range(1, 128)) :
                                   int'($urandom_range(mx + 1, 255));
      end
      PH_DC: begin
        v = $urandom_range(0, 1) ? -int'($urandom_range(8, 128)) :
                                   int'($urandom_range(248, 255));
      end
      default: begin
        // either out of range or a delta that lands the coefficient on zero
        if ($urandom_range(0, 1)) v = $urandom_range(128, 255);
        else v = (run <= 128) ? -run : 256 - run;
      end
    endcase
    return v;
  endfunction

  task automatic maybe_noise(input phase_e ph, input int mx, input int run, input logic rs);
    if ($urandom_range(0, 99) < 8) send_word(bad_value(ph, mx, run), rs);
  endtask

  // one walk over all lists of a set; a few walks break off in the middle of a list,
  // which leaves the block mid-list until the next restart
  task automatic walk_set(input logic rs_first, output logic finished);
    int   lists;
    int   cnt;
    int   run;
    int   d;
    int   cut;
    logic rs;
    logic explicit_list;
    logic abort;
    finished = 1'b0;
    rs       = rs_first;
    for (int sz = 0; sz < 4; sz++) begin
      lists = (sz == 3) ? 2 : MTX_COUNT;
      cnt   = (sz == 0) ? 16 : LIST_LEN;
      for (int mx = 0; mx < lists; mx++) begin
        if (sent >= ITEMS) return;
        // explicit lists are cheap at 4x4, expensive (64 words) above
        explicit_list = $urandom_range(0, 99) < ((sz == 0) ? 40 : 6);
        abort         = $urandom_range(0, 99) < 3;
        maybe_noise(PH_FLAG, mx, 0, rs);
        send_word(explicit_list ? 1 : 0, rs);
        rs = 1'b0;
        if (!explicit_list) begin
          if (abort) return;
          maybe_noise(PH_DELTA, mx, 0, 1'b0);
          send_word($urandom_range(0, mx), 1'b0);
        end else begin
          run = COEF_START;
          if (sz >= 2) begin
            maybe_noise(PH_DC, mx, 0, 1'b0);
            d = pick_dc();
            send_word(d, 1'b0);
            run = d + 8;
          end
          cut = abort ? $urandom_range(0, cnt - 1) : cnt;
          for (int i = 0; i < cut; i++) begin
            maybe_noise(PH_COEF, mx, run, 1'b0);
            d = pick_delta(run);
            send_word(d, 1'b0);
            run = (run + d) & 255;
          end
          if (abort) return;
        end
      end
    end
    finished = 1'b1;
  endtask

  initial begin : stimulus
    int   run;
    int   d;
    logic done_set;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // 4x4 matrix 0: bad mode flags, then a predicted list with bad deltas ahead of its good one
    send_word(2, 1'b0);
    send_word(255, 1'b0);
    send_word(-128, 1'b0);
    send_word(0, 1'b0);
    send_word(1, 1'b0);      // delta above the matrix number
    send_word(-1, 1'b0);     // negative delta
    send_word(0, 1'b0);      // default table copy
    // 4x4 matrix 1: explicit list, delta extremes, out of range and zero coefficient
    send_word(1, 1'b0);
    send_word(128, 1'b0);
    send_word(127, 1'b0);    // 8 -> 135
    send_word(-128, 1'b0);   // 135 -> 7
    send_word(-7, 1'b0);     // would give 0, dropped
    run = 7;
    for (int i = 2; i < 16; i++) begin
      d = pick_delta(run);
      send_word(d, 1'b0);
      run = (run + d) & 255;
    end
    // 4x4 matrix 2: copy of matrix 0, the largest legal delta here
    send_word(0, 1'b0);
    send_word(2, 1'b0);

    // random walks: the first and any after an aborted walk restart, others wrap or restart at random
    done_set = 1'b0;
    while (sent < ITEMS) walk_set(!done_set || $urandom_range(0, 1), done_set);
    in_valid <= 1'b0;

    // drain: wait for every expected result, then a little longer for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("sent %0d syntax words over random walks with noise, aborts and restarts",
             sent);
    $display("checked %0d result words, %0d full sets completed, %0d mismatching words",
             words_checked, sets_done, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- scaling_list_reconstruct_top.f -----
sv/slr_pkg.sv
sv/slr_ram.sv
sv/slr_ctrl.sv
sv/slr_dp.sv
sv/scaling_list_reconstruct_top.sv
tb/scaling_list_reconstruct_checker.sv
tb/scaling_list_reconstruct_top_tb.sv
